FILE: rtl/core/arm_step_collision_check_top_macros.svh
// Assertion macros shared by the collision check RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ARM_STEP_COLLISION_CHECK_TOP_MACROS_SVH
`define ARM_STEP_COLLISION_CHECK_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// condition that must hold at every clock edge
`define ASCC_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define ASCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASCC_ASSERT(label, expr, msg)
`define ASCC_ASSERT_IMP(label, ante, cons, msg)

`endif

`endif

FILE: rtl/core/ascc_pkg.sv
package ascc_pkg;

    localparam int TRIG_FRAC_BITS_DEF = 15;
    localparam int TRIG_FRAC_MAX      = 20;
    localparam int QUEUE_DEPTH_DEF    = 4;

    localparam int REG_W   = 15;
    localparam int ANGLE_W = 9;
    localparam int COORD_W = 16;
    localparam int IDX_W   = 3;

    localparam int SIN_ENTRIES = 91;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // quarter-wave sine table, one magnitude per whole degree 0..90
    typedef logic [SIN_ENTRIES-1:0][TRIG_FRAC_MAX:0] sin_tab_t;

    typedef enum logic [IDX_W-1:0] {
        REG_UPPER_LEN  = 3'd0,
        REG_FORE_LEN   = 3'd1,
        REG_TIP_OFFSET = 3'd2,
        REG_COL_RADIUS = 3'd3,
        REG_HEIGHT_LIM = 3'd4
    } cfg_reg_e;

    typedef enum logic [1:0] {
        JOINT_BASE     = 2'd0,
        JOINT_SHOULDER = 2'd1,
        JOINT_ELBOW    = 2'd2,
        JOINT_NONE     = 2'd3
    } joint_e;

    localparam logic DIR_MINUS = 1'b1;

    localparam logic [REG_W-1:0] UPPER_LEN_RST  = 15'd7578;
    localparam logic [REG_W-1:0] FORE_LEN_RST   = 15'd10445;
    localparam logic [REG_W-1:0] TIP_OFFSET_RST = 15'd11264;
    localparam logic [REG_W-1:0] COL_RADIUS_RST = 15'd3136;
    localparam logic [REG_W-1:0] HEIGHT_LIM_RST = 15'd14336;

    typedef struct packed {
        logic [REG_W-1:0] upper_len;
        logic [REG_W-1:0] fore_len;
        logic [REG_W-1:0] tip_offset;
        logic [REG_W-1:0] column_radius;
        logic [REG_W-1:0] height_limit;
    } cfg_t;

    // term / ((2n)(2n+1)) of the sine series
    function automatic logic [63:0] div_taylor(input logic [63:0] term, input int n);
        logic [63:0] q;
        case (n)
            1:       q = term / 64'd6;
            2:       q = term / 64'd20;
            3:       q = term / 64'd42;
            4:       q = term / 64'd72;
            5:       q = term / 64'd110;
            6:       q = term / 64'd156;
            7:       q = term / 64'd210;
            8:       q = term / 64'd272;
            9:       q = term / 64'd342;
            10:      q = term / 64'd420;
            11:      q = term / 64'd506;
            12:      q = term / 64'd600;
            13:      q = term / 64'd702;
            14:      q = term / 64'd812;
            15:      q = term / 64'd930;
            default: q = term;
        endcase
        return q;
    endfunction

    // elaboration-time table build: Q30 series, rounded half up to frac bits
    function automatic sin_tab_t build_sin_tab(input int frac);
        sin_tab_t    tab;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] rnd;
        longint      sum;
        int          drop;
        tab  = '0;
        drop = 30 - frac;
        for (int k = 0; k < SIN_ENTRIES; k++) begin
            x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 15; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = div_taylor(term, n);
                if (n[0])
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > (longint'(1) << 30))
                sum = longint'(1) << 30;
            rnd    = (64'(sum) + (64'd1 << (drop - 1))) >> drop;
            tab[k] = rnd[TRIG_FRAC_MAX:0];
        end
        return tab;
    endfunction

endpackage

FILE: rtl/core/ascc_front.sv
`include "arm_step_collision_check_top_macros.svh"

module ascc_front #(
    parameter int TRIG_FRAC_BITS = ascc_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [ascc_pkg::ANGLE_W-1:0]          base_angle,
    input  logic [ascc_pkg::ANGLE_W-1:0]          shoulder_angle,
    input  logic [ascc_pkg::ANGLE_W-1:0]          elbow_angle,
    input  logic [1:0]                            joint_select,
    input  logic                                  direction,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    // six {neg, magnitude} words: sin b, cos b, sin s, cos s, sin se, cos se
    output logic [6*(TRIG_FRAC_BITS+2)-1:0]       trig_word
);
    import ascc_pkg::*;

    localparam int MW = TRIG_FRAC_BITS + 1;
    localparam int EW = MW + 1;
    localparam sin_tab_t SIN_TAB = build_sin_tab(TRIG_FRAC_BITS);

    typedef struct packed {
        logic       neg;
        logic [6:0] idx;
    } trig_ref_t;

    typedef logic [ANGLE_W-1:0] angle_t;

    function automatic angle_t mod360(input angle_t a);
        return (a >= 9'd360) ? a - 9'd360 : a;
    endfunction

    function automatic angle_t step1(input angle_t a, input logic dir);
        angle_t r;
        if (dir == DIR_MINUS)
            r = (a == 9'd0) ? 9'd359 : a - 9'd1;
        else
            r = (a == 9'd359) ? 9'd0 : a + 9'd1;
        return r;
    endfunction

    // quadrant fold: sign and table index for sin(a), a in 0..359
    function automatic trig_ref_t sin_ref(input angle_t a);
        trig_ref_t t;
        angle_t    d;
        if (a >= 9'd270) begin
            d = 9'd360 - a;
            t.neg = 1'b1;
        end else if (a >= 9'd180) begin
            d = a - 9'd180;
            t.neg = 1'b1;
        end else if (a >= 9'd90) begin
            d = 9'd180 - a;
            t.neg = 1'b0;
        end else begin
            d = a;
            t.neg = 1'b0;
        end
        t.idx = d[6:0];
        return t;
    endfunction

    function automatic angle_t cos_arg(input angle_t a);
        return (a >= 9'd270) ? a - 9'd270 : a + 9'd90;
    endfunction

    logic                 en_f;
    logic                 va_reg;
    logic                 vb_reg;
    trig_ref_t            ref_reg  [6];
    trig_ref_t            ref_next [6];
    logic [6*EW-1:0]      word_reg;
    logic [6*EW-1:0]      word_next;
    angle_t               b_ang;
    angle_t               s_ang;
    angle_t               e_ang;
    angle_t               se_ang;
    logic [ANGLE_W:0]     se_sum;

    assign en_f      = !vb_reg || out_ready;
    assign in_ready  = en_f;
    assign out_valid = vb_reg;
    assign trig_word = word_reg;

    // stage A: reduce, step the selected joint, fold to table refs
    always_comb
    begin
        b_ang = mod360(base_angle);
        s_ang = mod360(shoulder_angle);
        e_ang = mod360(elbow_angle);
        unique case (joint_select)
            JOINT_BASE:     b_ang = step1(b_ang, direction);
            JOINT_SHOULDER: s_ang = step1(s_ang, direction);
            JOINT_ELBOW:    e_ang = step1(e_ang, direction);
            JOINT_NONE:     ;
            default:        ;
        endcase
        se_sum = {1'b0, s_ang} + {1'b0, e_ang};
        se_ang = (se_sum >= 10'd360) ? 9'(se_sum - 10'd360) : se_sum[ANGLE_W-1:0];
        ref_next[0] = sin_ref(b_ang);
        ref_next[1] = sin_ref(cos_arg(b_ang));
        ref_next[2] = sin_ref(s_ang);
        ref_next[3] = sin_ref(cos_arg(s_ang));
        ref_next[4] = sin_ref(se_ang);
        ref_next[5] = sin_ref(cos_arg(se_ang));
    end

    // stage B: table reads
    always_comb
    begin
        for (int k = 0; k < 6; k++)
            word_next[k*EW +: EW] = {ref_reg[k].neg, SIN_TAB[ref_reg[k].idx][MW-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en_f) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f) begin
            ref_reg  <= ref_next;
            word_reg <= word_next;
        end
    end

    `ASCC_ASSERT_IMP(a_front_advance, $past(en_f), vb_reg == $past(va_reg), "front stage lost a word")

endmodule

FILE: rtl/core/ascc_queue.sv
`include "arm_step_collision_check_top_macros.svh"

module ascc_queue #(
    parameter int W     = 8,
    parameter int DEPTH = ascc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_data;
    end

    `ASCC_ASSERT(a_q_bound, count_reg <= CNT_FULL, "queue count above depth")
    `ASCC_ASSERT_IMP(a_q_push, $past(push && !pop), count_reg == $past(count_reg) + 1'b1, "queue count missed a push")

endmodule

FILE: rtl/core/ascc_back.sv
`include "arm_step_collision_check_top_macros.svh"

module ascc_back #(
    parameter int TRIG_FRAC_BITS = ascc_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ascc_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [6*(TRIG_FRAC_BITS+2)-1:0]     in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                move_allowed,
    output logic signed [ascc_pkg::COORD_W-1:0] tip_x,
    output logic signed [ascc_pkg::COORD_W-1:0] tip_height,
    output logic signed [ascc_pkg::COORD_W-1:0] tip_z
);
    import ascc_pkg::*;

    localparam int TF    = TRIG_FRAC_BITS;
    localparam int MW    = TF + 1;            // trig magnitude
    localparam int EW    = MW + 1;            // {neg, magnitude}
    localparam int PW    = REG_W + MW;        // link * trig magnitude
    localparam int RW    = PW + 1;            // signed reach
    localparam int RMW   = PW;                // reach magnitude
    localparam int HW    = PW + 2;            // signed unrounded height
    localparam int HMW   = HW - 1;            // its magnitude
    localparam int EXW   = PW + 1 - TF;       // rounded elbow radius
    localparam int LOW_W = RMW / 2;           // reach split for the b multiply
    localparam int HIW   = RMW - LOW_W;
    localparam int FULLW = MW + RMW;
    localparam int TXM_W = COORD_W + 1;       // rounded tip x/z magnitude
    localparam int TXS_W = COORD_W + 2;
    localparam int HRW   = HMW + 1 - TF;      // rounded height magnitude
    localparam int HS_W  = HRW + 1;
    localparam int SQ_W  = 2 * TXM_W;
    localparam int CR2_W = 2 * REG_W;

    localparam logic [PW:0]      EX_HALF = {{PW{1'b0}}, 1'b1} << (TF - 1);
    localparam logic [HMW:0]     H_HALF  = {{HMW{1'b0}}, 1'b1} << (TF - 1);
    localparam logic [FULLW-1:0] FX_HALF = {{(FULLW-1){1'b0}}, 1'b1} << (2*TF - 1);
    localparam logic signed [HS_W-1:0] SAT_HI = HS_W'(32767);
    localparam logic signed [HS_W-1:0] SAT_LO = -HS_W'(32768);

    function automatic logic [COORD_W-1:0] sat16(input logic signed [HS_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v > SAT_HI)
            r = 16'h7fff;
        else if (v < SAT_LO)
            r = 16'h8000;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    logic en;

    // valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;

    logic [CR2_W-1:0] cr2_reg;

    // stage 1
    logic [PW-1:0]  p1c_reg, p2c_reg, p1s_reg, p2s_reg;
    logic           c1n_reg, c2n_reg, s1n_reg, s2n_reg;
    logic [EW-1:0]  sb1_reg, cb1_reg;
    logic [EW-1:0]  f_sinb, f_cosb, f_sins, f_coss, f_sinse, f_cosse;

    // stage 2
    logic signed [RW-1:0] reach_reg, reach_next;
    logic signed [HW-1:0] hfull_reg, hfull_next;
    logic [EXW-1:0]       exm_reg;
    logic [EW-1:0]        sb2_reg, cb2_reg;
    logic signed [RW-1:0] t_c1, t_c2;
    logic signed [HW-1:0] t_s1, t_s2, off_ext;
    logic [PW:0]          ex_sum;

    // stage 3
    logic                 rneg_reg;
    logic [RMW-1:0]       rmag_reg;
    logic                 hneg3_reg;
    logic [HMW-1:0]       hmag_reg;
    logic [2*EXW-1:0]     exsq_reg;
    logic [EW-1:0]        sb3_reg, cb3_reg;
    logic signed [RW-1:0] abs_r;
    logic signed [HW-1:0] abs_h;

    // stage 4
    logic                 txn4_reg, tzn4_reg, hneg4_reg, elbow4_reg;
    logic [MW+LOW_W-1:0]  sblo_reg, cblo_reg;
    logic [MW+HIW-1:0]    sbhi_reg, cbhi_reg;
    logic [HRW-1:0]       hrm_reg;
    logic [HMW:0]         h_sum;

    // stage 5
    logic [TXM_W-1:0]       txm_reg, tzm_reg;
    logic                   txn5_reg, tzn5_reg, elbow5_reg;
    logic signed [HS_W-1:0] hs5_reg;
    logic [FULLW-1:0]       fx, fz;

    // stage 6
    logic signed [TXS_W-1:0] tx6_reg, tz6_reg;
    logic [SQ_W-1:0]         txsq_reg, tzsq_reg;
    logic signed [HS_W-1:0]  hs6_reg;
    logic                    hhi_reg, hok_reg, elbow6_reg;

    // stage 7 / output
    logic                    allowed_reg;
    logic [COORD_W-1:0]      tipx_reg, tiph_reg, tipz_reg;
    logic [SQ_W:0]           sq_sum;

    assign en        = !v7_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v7_reg;
    assign move_allowed = allowed_reg;
    assign tip_x      = tipx_reg;
    assign tip_height = tiph_reg;
    assign tip_z      = tipz_reg;

    assign f_sinb  = in_data[0*EW +: EW];
    assign f_cosb  = in_data[1*EW +: EW];
    assign f_sins  = in_data[2*EW +: EW];
    assign f_coss  = in_data[3*EW +: EW];
    assign f_sinse = in_data[4*EW +: EW];
    assign f_cosse = in_data[5*EW +: EW];

    // stage 2: signed sums of the link terms, elbow radius rounding
    always_comb
    begin
        t_c1 = {1'b0, p1c_reg};
        t_c2 = {1'b0, p2c_reg};
        if (c1n_reg) t_c1 = -t_c1;
        if (c2n_reg) t_c2 = -t_c2;
        reach_next = t_c1 + t_c2;
        t_s1 = {2'b00, p1s_reg};
        t_s2 = {2'b00, p2s_reg};
        if (s1n_reg) t_s1 = -t_s1;
        if (s2n_reg) t_s2 = -t_s2;
        off_ext    = {{(HW-REG_W-TF){1'b0}}, cfg.tip_offset, {TF{1'b0}}};
        hfull_next = off_ext - t_s1 - t_s2;
        ex_sum     = {1'b0, p1c_reg} + EX_HALF;
    end

    // stage 3: magnitudes
    assign abs_r = reach_reg[RW-1] ? -reach_reg : reach_reg;
    assign abs_h = hfull_reg[HW-1] ? -hfull_reg : hfull_reg;

    // stage 4: height rounding
    assign h_sum = {1'b0, hmag_reg} + H_HALF;

    // stage 5: join partial products and round to unsigned Q17.0 magnitudes
    assign fx = FULLW'(sblo_reg) + (FULLW'(sbhi_reg) << LOW_W) + FX_HALF;
    assign fz = FULLW'(cblo_reg) + (FULLW'(cbhi_reg) << LOW_W) + FX_HALF;

    // stage 7: squared tip radius
    assign sq_sum = {1'b0, txsq_reg} + {1'b0, tzsq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // column radius squared; the user must keep settings static while items are in flight (not enforced here)
    always_ff @(posedge clk)
    begin
        cr2_reg <= cfg.column_radius * cfg.column_radius;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            // stage 1: link products
            p1c_reg <= cfg.upper_len * f_coss[MW-1:0];
            p2c_reg <= cfg.fore_len  * f_cosse[MW-1:0];
            p1s_reg <= cfg.upper_len * f_sins[MW-1:0];
            p2s_reg <= cfg.fore_len  * f_sinse[MW-1:0];
            c1n_reg <= f_coss[MW];
            c2n_reg <= f_cosse[MW];
            s1n_reg <= f_sins[MW];
            s2n_reg <= f_sinse[MW];
            sb1_reg <= f_sinb;
            cb1_reg <= f_cosb;
            // stage 2
            reach_reg <= reach_next;
            hfull_reg <= hfull_next;
            exm_reg   <= ex_sum[PW:TF];
            sb2_reg   <= sb1_reg;
            cb2_reg   <= cb1_reg;
            // stage 3
            rneg_reg  <= reach_reg[RW-1];
            rmag_reg  <= abs_r[RMW-1:0];
            hneg3_reg <= hfull_reg[HW-1];
            hmag_reg  <= abs_h[HMW-1:0];
            exsq_reg  <= exm_reg * exm_reg;
            sb3_reg   <= sb2_reg;
            cb3_reg   <= cb2_reg;
            // stage 4: split multiply by sin b / cos b
            sblo_reg   <= sb3_reg[MW-1:0] * rmag_reg[LOW_W-1:0];
            sbhi_reg   <= sb3_reg[MW-1:0] * rmag_reg[RMW-1:LOW_W];
            cblo_reg   <= cb3_reg[MW-1:0] * rmag_reg[LOW_W-1:0];
            cbhi_reg   <= cb3_reg[MW-1:0] * rmag_reg[RMW-1:LOW_W];
            txn4_reg   <= sb3_reg[MW] ^ rneg_reg;
            tzn4_reg   <= cb3_reg[MW] ^ rneg_reg;
            hneg4_reg  <= hneg3_reg;
            hrm_reg    <= h_sum[HMW:TF];
            elbow4_reg <= exsq_reg > {{(2*EXW-CR2_W){1'b0}}, cr2_reg};
            // stage 5
            txm_reg    <= fx[2*TF+COORD_W:2*TF];
            tzm_reg    <= fz[2*TF+COORD_W:2*TF];
            txn5_reg   <= txn4_reg;
            tzn5_reg   <= tzn4_reg;
            hs5_reg    <= hneg4_reg ? -$signed({1'b0, hrm_reg}) : $signed({1'b0, hrm_reg});
            elbow5_reg <= elbow4_reg;
            // stage 6
            tx6_reg    <= txn5_reg ? -$signed({1'b0, txm_reg}) : $signed({1'b0, txm_reg});
            tz6_reg    <= tzn5_reg ? -$signed({1'b0, tzm_reg}) : $signed({1'b0, tzm_reg});
            txsq_reg   <= txm_reg * txm_reg;
            tzsq_reg   <= tzm_reg * tzm_reg;
            hs6_reg    <= hs5_reg;
            hhi_reg    <= hs5_reg > $signed({{(HS_W-REG_W){1'b0}}, cfg.height_limit});
            hok_reg    <= !hs5_reg[HS_W-1];
            elbow6_reg <= elbow5_reg;
            // stage 7: tests and saturation
            allowed_reg <= ((sq_sum > {{(SQ_W+1-CR2_W){1'b0}}, cr2_reg}) || hhi_reg)
                           && elbow6_reg && hok_reg;
            tipx_reg    <= sat16({tx6_reg[TXS_W-1], tx6_reg});
            tiph_reg    <= sat16(hs6_reg);
            tipz_reg    <= sat16({tz6_reg[TXS_W-1], tz6_reg});
        end
    end

    `ASCC_ASSERT_IMP(a_back_fill, $past(en), v1_reg == $past(in_valid), "back pipe dropped a word")
    `ASCC_ASSERT_IMP(a_allowed_floor, out_valid && move_allowed, !tip_height[COORD_W-1], "move allowed below floor")

endmodule

FILE: rtl/core/arm_step_collision_check_top.sv
// Path of a word: front stages, decoupling queue, back pipe, output register.
// Throughput: one word per cycle; every stage is a register, no shared unit.
// Output stall freezes the back pipe; the 4-deep queue lets the front run until full.
// Reset (rst_n low, async): all valids clear, queue empties, settings return to defaults.
// No clearing pass after reset; the first word is taken at the first edge after release.
module arm_step_collision_check_top #(
    parameter int TRIG_FRAC_BITS = ascc_pkg::TRIG_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH    = ascc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave stream: pose and step request
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [8:0] base_angle, [17:9] shoulder_angle, [26:18] elbow_angle,
    // [28:27] joint_select, [29] direction, [31:30] zero
    input  logic [31:0]                     s_axis_tdata,
    // master stream: check result
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] move_allowed, [16:1] tip_x, [32:17] tip_height, [48:33] tip_z, [55:49] zero
    output logic [55:0]                     m_axis_tdata,
    // settings write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ascc_pkg::IDX_W-1:0]      cfg_index,
    input  logic [ascc_pkg::REG_W-1:0]      cfg_data
);
    import ascc_pkg::*;

    localparam int EW = TRIG_FRAC_BITS + 2;
    localparam int TW = 6 * EW;

    cfg_t cfg_reg;

    logic          f_valid;
    logic          f_ready;
    logic [TW-1:0] f_word;
    logic          q_valid;
    logic          q_ready;
    logic [TW-1:0] q_word;

    logic                       move_allowed;
    logic signed [COORD_W-1:0]  tip_x;
    logic signed [COORD_W-1:0]  tip_height;
    logic signed [COORD_W-1:0]  tip_z;

    // settings: always ready, unknown indexes ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.upper_len     <= UPPER_LEN_RST;
            cfg_reg.fore_len      <= FORE_LEN_RST;
            cfg_reg.tip_offset    <= TIP_OFFSET_RST;
            cfg_reg.column_radius <= COL_RADIUS_RST;
            cfg_reg.height_limit  <= HEIGHT_LIM_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_UPPER_LEN:  cfg_reg.upper_len     <= cfg_data;
                REG_FORE_LEN:   cfg_reg.fore_len      <= cfg_data;
                REG_TIP_OFFSET: cfg_reg.tip_offset    <= cfg_data;
                REG_COL_RADIUS: cfg_reg.column_radius <= cfg_data;
                REG_HEIGHT_LIM: cfg_reg.height_limit  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // front: angle step, wrap, quadrant fold, sin/cos table reads
    ascc_front #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .base_angle     (s_axis_tdata[8:0]),
        .shoulder_angle (s_axis_tdata[17:9]),
        .elbow_angle    (s_axis_tdata[26:18]),
        .joint_select   (s_axis_tdata[28:27]),
        .direction      (s_axis_tdata[29]),
        .out_valid      (f_valid),
        .out_ready      (f_ready),
        .trig_word      (f_word)
    );

    // decoupling queue between front and back
    ascc_queue #(
        .W     (TW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_word),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_word)
    );

    // back: kinematics, rounding, clearance tests, output register
    ascc_back #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_data      (q_word),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .move_allowed (move_allowed),
        .tip_x        (tip_x),
        .tip_height   (tip_height),
        .tip_z        (tip_z)
    );

    assign m_axis_tdata = {7'b0, tip_z, tip_height, tip_x, move_allowed};

endmodule
